>>> hw/rtl/msr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_pkg
// Shared constants and types of the multi-servo linear ramp unit.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int SERVO_COUNT   = 8;
  localparam int CH_W          = 3;
  localparam int WIDTH_W       = 16;
  localparam int FRACTION_BITS = 8;
  localparam int FIX_W         = WIDTH_W + FRACTION_BITS;
  localparam int PROD_W        = FIX_W + WIDTH_W;
  localparam int ITER_W        = $clog2(FIX_W);

  localparam logic [WIDTH_W-1:0] REST_WIDTH = 16'd1500;
  localparam logic [FIX_W-1:0]   REST_FIXED = {REST_WIDTH, {FRACTION_BITS{1'b0}}};

  // Input kinds carried in tuser
  localparam logic MODE_SET  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Request to the shared multiply/divide unit
  typedef struct packed {
    logic               start;
    logic [FIX_W-1:0]   mag;
    logic [WIDTH_W-1:0] step;
    logic [WIDTH_W-1:0] len;
  } div_req_t;

  // Answer of the shared multiply/divide unit
  typedef struct packed {
    logic             done;
    logic [FIX_W-1:0] quo;
  } div_rsp_t;

endpackage

>>> hw/rtl/msr_ramp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_ramp_div
// Scale a magnitude by step, then divide by len with a restoring divider,
// one quotient bit per cycle. The quotient never exceeds the magnitude.
// ----------------------------------------------------------------------------
module msr_ramp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  msr_pkg::div_req_t req,
  output msr_pkg::div_rsp_t rsp
);
  import msr_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [WIDTH_W-1:0] rem_r;
  logic [FIX_W-1:0]  quo_r;
  logic [WIDTH_W-1:0] len_r;

  logic [PROD_W-1:0]  prod;
  logic [WIDTH_W:0]   trial;
  logic [WIDTH_W:0]   diff;
  logic               ge;

  // Product of magnitude and step; the upper part is already below len
  assign prod  = PROD_W'(req.mag) * PROD_W'(req.step);

  // One restoring step
  assign trial = {rem_r, quo_r[FIX_W-1]};
  assign diff  = trial - {1'b0, len_r};
  assign ge    = (trial >= {1'b0, len_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ITER_W'(FIX_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= prod[PROD_W-1:FIX_W];
      quo_r <= prod[FIX_W-1:0];
      len_r <= req.len;
    end else if (busy_r) begin
      rem_r <= ge ? diff[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
      quo_r <= {quo_r[FIX_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

>>> hw/rtl/multi_servo_linear_ramp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_servo_linear_ramp_unit
// Eight-channel servo ramp generator with linear interpolation per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a kind in in_tuser. A set-target beat (kind 0) writes the
//   ramp of one channel, leaves in_tready high and yields no result. A tick beat
//   (kind 1) walks channels 0..7; every channel with a running ramp advances
//   one step and yields one output beat (channel, whole-microsecond position),
//   in channel order, with out_tlast on the final beat of that tick.
//   Sequence: an idle channel is only scanned; a running channel passes through
//   scan and operand setup, launch with the multiply, 24 restoring divide
//   steps, the done response that updates the position, and emit; the
//   multiply and divide use the one shared multiply/divide unit. in_tready
//   stays low for the whole walk of a tick.
//   The result sits in an output register; if the receiver stalls, the walk
//   continues until the next result needs that register, then holds.
//   Reset parks every channel at 1500 us with no ramp running and empties
//   the output register.
// ----------------------------------------------------------------------------
module multi_servo_linear_ramp_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // servo[2:0], target_width[18:3], duration_ticks[34:19]
  input  logic [0:0]  in_tuser,   // mode[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // channel[2:0], position_width[18:3]
  output logic        out_tlast
);
  import msr_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_LAUNCH = 3'd2;
  localparam logic [2:0] ST_WAIT   = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Channel state
  logic [FIX_W-1:0]   pos_r   [SERVO_COUNT];
  logic [FIX_W-1:0]   start_r [SERVO_COUNT];
  logic [WIDTH_W-1:0] end_r   [SERVO_COUNT];
  logic [WIDTH_W-1:0] dur_r   [SERVO_COUNT];
  logic [WIDTH_W-1:0] step_r  [SERVO_COUNT];

  logic [SERVO_COUNT-1:0] act_r;
  logic [CH_W-1:0]        ch_r;
  logic [FIX_W-1:0]       mag_r;
  logic                   neg_r;
  logic [WIDTH_W-1:0]     stepn_r;

  logic               out_valid_r;
  logic [CH_W-1:0]    out_ch_r;
  logic [WIDTH_W-1:0] out_pos_r;
  logic               out_last_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic               in_fire;
  logic [CH_W-1:0]    in_servo;
  logic [WIDTH_W-1:0] in_target;
  logic [WIDTH_W-1:0] in_dur;
  logic [FIX_W:0]     ramp_diff;
  logic [FIX_W:0]     ramp_abs;
  logic [FIX_W-1:0]   new_pos;
  logic [SERVO_COUNT-1:0] act_rest;
  logic               is_last;
  logic               out_free;
  logic               emit_go;
  logic               ch_end;
  logic [SERVO_COUNT-1:0] act_now;

  // Unpack the input beat
  assign in_servo  = in_tdata[2:0];
  assign in_target = in_tdata[18:3];
  assign in_dur    = in_tdata[34:19];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Running ramps at the start of a tick
  always_comb begin
    for (int i = 0; i < SERVO_COUNT; i++) begin
      act_now[i] = (dur_r[i] != '0);
    end
  end

  // Signed distance from ramp start to ramp end
  assign ramp_diff = {1'b0, end_r[ch_r], {FRACTION_BITS{1'b0}}} - {1'b0, start_r[ch_r]};
  assign ramp_abs  = ramp_diff[FIX_W] ? (~ramp_diff + 1'b1) : ramp_diff;

  // Apply the truncated quotient in the direction of the ramp
  assign new_pos = neg_r ? (start_r[ch_r] - div_rsp.quo) : (start_r[ch_r] + div_rsp.quo);

  // No running channel above the current one means last beat of the tick
  assign act_rest = act_r >> ch_r;
  assign is_last  = (act_rest[SERVO_COUNT-1:1] == '0);

  assign out_free = !out_valid_r || out_tready;
  assign emit_go  = (state_r == ST_EMIT) && out_free;
  assign ch_end   = (ch_r == CH_W'(SERVO_COUNT - 1));

  // Shared unit request
  assign div_req.start = (state_r == ST_LAUNCH);
  assign div_req.mag   = mag_r;
  assign div_req.step  = stepn_r;
  assign div_req.len   = dur_r[ch_r];

  msr_ramp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser[0] == MODE_TICK)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (act_r[ch_r])  state_nxt = ST_LAUNCH;
        else if (ch_end)  state_nxt = ST_IDLE;
      end
      ST_LAUNCH: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (div_rsp.done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) state_nxt = ch_end ? ST_IDLE : ST_SCAN;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Channel walk and operand setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r  <= '0;
      act_r <= '0;
    end else begin
      if (in_fire && (in_tuser[0] == MODE_TICK)) begin
        ch_r  <= '0;
        act_r <= act_now;
      end else if ((state_r == ST_SCAN) && !act_r[ch_r] && !ch_end) begin
        ch_r <= ch_r + 1'b1;
      end else if (emit_go && !ch_end) begin
        ch_r <= ch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCAN) begin
      mag_r   <= ramp_abs[FIX_W-1:0];
      neg_r   <= ramp_diff[FIX_W];
      stepn_r <= step_r[ch_r] + 1'b1;
    end
  end

  // Channel state: set-target writes and ramp updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        pos_r[i]   <= REST_FIXED;
        start_r[i] <= REST_FIXED;
        end_r[i]   <= REST_WIDTH;
        dur_r[i]   <= '0;
        step_r[i]  <= '0;
      end
    end else begin
      if (in_fire && (in_tuser[0] == MODE_SET)) begin
        start_r[in_servo] <= pos_r[in_servo];
        end_r[in_servo]   <= in_target;
        dur_r[in_servo]   <= in_dur;
        step_r[in_servo]  <= '0;
      end
      if ((state_r == ST_WAIT) && div_rsp.done) begin
        pos_r[ch_r] <= new_pos;
        if (stepn_r >= dur_r[ch_r]) begin
          step_r[ch_r] <= '0;
          dur_r[ch_r]  <= '0;
        end else begin
          step_r[ch_r] <= stepn_r;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_ch_r   <= ch_r;
      out_pos_r  <= pos_r[ch_r][FIX_W-1:FRACTION_BITS];
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_pos_r, out_ch_r};
  assign out_tlast  = out_last_r;

endmodule

>>> hw/rtl/msr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msr_checker
// Port-level checks of the multi-servo linear ramp unit, bound to the top.
// ----------------------------------------------------------------------------
module msr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);
  import msr_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // A tick keeps the block busy while it walks the channels
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == MODE_TICK) |=> !in_tready)
    else $error("input accepted during tick walk");

  // A set-target beat does not stall the input
  a_set_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == MODE_SET) |=> in_tready)
    else $error("set-target beat stalled the input");

  // Pad bits of a result beat stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[23:19] == 5'b0))
    else $error("nonzero pad bits in result beat");

endmodule

bind multi_servo_linear_ramp_unit msr_checker u_msr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-servo linear ramp unit. Input beats are
// set-target and tick items; every accepted beat runs through a predictor of
// the eight ramp channels, and every output beat is checked in order against
// the predicted channel, position and last flag. Both sides idle at random,
// the receiver holds off for a long stretch once, and the sender drains twice.
// ----------------------------------------------------------------------------
module tb_top;
  import msr_pkg::*;

  // The slowest correct run stays well under this limit.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES  = 3000;
  localparam int RANDOM_ITEMS = 75;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [WIDTH_W-1:0] position;
    logic               last;
  } servo_beat_t;

  // --------------------------------------------------------------------------
  // Predicts the ramp channels and checks output beats in order
  // --------------------------------------------------------------------------
  class ramp_scoreboard;
    logic [FIX_W-1:0]   pos_fx[SERVO_COUNT];
    logic [FIX_W-1:0]   start_fx[SERVO_COUNT];
    logic [WIDTH_W-1:0] end_w[SERVO_COUNT];
    logic [WIDTH_W-1:0] ramp_len[SERVO_COUNT];
    logic [WIDTH_W-1:0] step_cnt[SERVO_COUNT];
    servo_beat_t        expected_beats[$];
    int                 errors;

    function new();
      errors = 0;
      for (int i = 0; i < SERVO_COUNT; i++) begin
        pos_fx[i]   = REST_FIXED;
        start_fx[i] = REST_FIXED;
        end_w[i]    = REST_WIDTH;
        ramp_len[i] = '0;
        step_cnt[i] = '0;
      end
    endfunction

    // start + ((end << frac) - start) * step / len, truncated toward zero
    function logic [FIX_W-1:0] interpolate_position(logic [FIX_W-1:0] from_fx,
                                                    logic [WIDTH_W-1:0] to_w,
                                                    logic [WIDTH_W-1:0] n,
                                                    logic [WIDTH_W-1:0] len);
      longint s;
      longint e;
      longint sn;
      longint sl;
      longint sum;
      s   = longint'(from_fx);
      e   = longint'({to_w, {FRACTION_BITS{1'b0}}});
      sn  = longint'(n);
      sl  = longint'(len);
      sum = s + ((e - s) * sn) / sl;
      return sum[FIX_W-1:0];
    endfunction

    // Update the channel state and queue the beats a tick produces
    function void note_input(logic mode, logic [CH_W-1:0] servo,
                             logic [WIDTH_W-1:0] target, logic [WIDTH_W-1:0] dur);
      int n;
      n = 0;
      if (mode == MODE_SET) begin
        start_fx[servo] = pos_fx[servo];
        end_w[servo]    = target;
        ramp_len[servo] = dur;
        step_cnt[servo] = '0;
        return;
      end
      for (int i = 0; i < SERVO_COUNT; i++) begin
        if (ramp_len[i] != 0) begin
          if (step_cnt[i] < ramp_len[i]) begin
            step_cnt[i] = step_cnt[i] + 1'b1;
            pos_fx[i] = interpolate_position(start_fx[i], end_w[i], step_cnt[i],
                                             ramp_len[i]);
          end
          if (step_cnt[i] >= ramp_len[i]) begin
            step_cnt[i] = '0;
            ramp_len[i] = '0;
          end
          expected_beats.push_back('{channel: i[CH_W-1:0],
                                     position: pos_fx[i][FIX_W-1:FRACTION_BITS],
                                     last: 1'b0});
          n++;
        end
      end
      if (n > 0) expected_beats[expected_beats.size()-1].last = 1'b1;
    endfunction

    // Compare one output beat with the oldest expectation
    function void check_result(logic [CH_W-1:0] ch, logic [WIDTH_W-1:0] pos,
                               logic last);
      servo_beat_t want;
      servo_beat_t got;
      got = '{channel: ch, position: pos, last: last};
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat ch=%0d pos=%0d last=%0b",
                 $time, ch, pos, last);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      if (want !== got) begin
        $display("%0t: mismatch expected ch=%0d pos=%0d last=%0b, got ch=%0d pos=%0d last=%0b",
                 $time, want.channel, want.position, want.last,
                 got.channel, got.position, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;  // servo[2:0], target_width[18:3], duration_ticks[34:19]
  logic [0:0]  in_tuser   = '0;  // mode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // channel[2:0], position_width[18:3]
  logic        out_tlast;

  int send_idle_pct = 28;
  int recv_idle_pct = 80;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;

  ramp_scoreboard sb;

  multi_servo_linear_ramp_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort on a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Drive out_tready: long hold-off on request, else random stalls
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata[2:0], out_tdata[18:3], out_tlast);
      if (in_tvalid && in_tready)
        sb.note_input(in_tuser[0], in_tdata[2:0], in_tdata[18:3], in_tdata[34:19]);
    end
  end

  // Offer one beat; entered and left at a falling edge, tvalid left high
  task automatic send_beat(input logic mode, input logic [2:0] servo,
                           input logic [15:0] target, input logic [15:0] dur);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {5'b0, dur, target, servo};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop tvalid and wait for every expected beat
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (sb.expected_beats.size() != 0);
  endtask

  // Mostly sets with short ramps and ticks; some extremes and long ramps
  task automatic send_random_items(input int count);
    logic [15:0] target;
    logic [15:0] dur;
    int          pick;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 35) begin
        pick = $urandom_range(99);
        if (pick < 15) target = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        else           target = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 10)      dur = 16'd0;
        else if (pick < 80) dur = 16'($urandom_range(6, 1));
        else if (pick < 95) dur = 16'($urandom_range(40, 7));
        else                dur = 16'($urandom);
        send_beat(MODE_SET, 3'($urandom_range(7)), target, dur);
      end else begin
        send_beat(MODE_TICK, 3'($urandom_range(7)), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: idle tick, extremes, zero duration, flat and falling ramps
    send_beat(MODE_TICK, 3'd0, 16'h0000, 16'h0000);
    send_beat(MODE_SET, 3'd0, 16'h0000, 16'd1);
    send_beat(MODE_SET, 3'd7, 16'hFFFF, 16'd3);
    send_beat(MODE_SET, 3'd3, 16'd1000, 16'd0);
    send_beat(MODE_SET, 3'd1, 16'd2000, 16'hFFFF);
    send_beat(MODE_SET, 3'd4, REST_WIDTH, 16'd2);
    send_beat(MODE_SET, 3'd5, 16'd1, 16'd7);
    send_beat(MODE_TICK, 3'd7, 16'hFFFF, 16'hFFFF);
    send_beat(MODE_TICK, 3'd2, 16'h5A5A, 16'hA5A5);
    // retarget a channel mid-ramp and start the zero-duration one
    send_beat(MODE_SET, 3'd7, 16'h0000, 16'd5);
    send_beat(MODE_SET, 3'd3, 16'hFFFF, 16'd2);
    for (int k = 0; k < 6; k++)
      send_beat(MODE_TICK, 3'($urandom_range(7)), 16'($urandom), 16'($urandom));
    send_beat(MODE_SET, 3'd1, 16'd0, 16'd0);

    // Random, sender idles lightly and receiver heavily
    send_random_items(RANDOM_ITEMS);

    // Random, the other way round
    send_idle_pct = 80;
    recv_idle_pct = 28;
    send_random_items(RANDOM_ITEMS);

    // No idling; first fill the block behind a long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < SERVO_COUNT; i++)
      send_beat(MODE_SET, i[2:0], 16'($urandom), 16'd20);
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++)
      send_beat(MODE_TICK, 3'($urandom_range(7)), 16'($urandom), 16'($urandom));
    drain_results();
    send_random_items(RANDOM_ITEMS);

    // Let any tick without beats finish before ending
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
